// File: rtl/primitive_cull_and_command_build_top_defines.svh
// ----------------------------------------------------------------------------
// primitive_cull_and_command_build_top_defines
// Assertion macros used by the RTL serializer.
// ----------------------------------------------------------------------------
`ifndef PRIMITIVE_CULL_AND_COMMAND_BUILD_TOP_DEFINES_SVH
`define PRIMITIVE_CULL_AND_COMMAND_BUILD_TOP_DEFINES_SVH
// assert that a implies b on the same edge
`define PCCB_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// assert that a implies b on the next edge
`define PCCB_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

// File: rtl/pccb_pkg.sv
// ----------------------------------------------------------------------------
// pccb_pkg
// Types, constants and helpers for primitive cull and command build.
// ----------------------------------------------------------------------------
package pccb_pkg;
	localparam logic [31:0] CMD_G4    = 32'h08000000;
	localparam logic [31:0] CMD_G4C   = 32'h38000000;
	localparam logic [31:0] CMD_FT4C  = 32'h2c000000;
	localparam logic [31:0] CMD_GT4C  = 32'h3c000000;
	localparam logic [31:0] CMD_G3    = 32'h06000000;
	localparam logic [31:0] CMD_G3C   = 32'h30000000;
	localparam logic [31:0] CMD_GT3C  = 32'h34000000;
	localparam logic [31:0] CMD_T9    = 32'h09000000;
	localparam logic [31:0] CMD_T12   = 32'h0c000000;
	localparam logic [31:0] COL_MASK  = 32'h00ffffff;
	localparam logic [31:0] HI_MASK   = 32'hffff0000;

	typedef enum logic [2:0] {
		RSN_NONE = 3'd0, RSN_OUTCODE = 3'd1, RSN_SKIP = 3'd2, RSN_BACK = 3'd3,
		RSN_ZERO = 3'd4, RSN_DEPTH = 3'd5, RSN_LIGHT = 3'd6
	} reason_t;

	typedef enum logic [2:0] {
		KIND_G3 = 3'd0, KIND_GT3 = 3'd1, KIND_G4 = 3'd2, KIND_GT4 = 3'd3, KIND_BB = 3'd4
	} kind_t;

	localparam logic [1:0] CFG_ORIGIN = 2'd0;
	localparam logic [1:0] CFG_SHIFT  = 2'd1;
	localparam logic [1:0] CFG_FOG    = 2'd2;

	typedef struct packed {
		logic [31:0] depth_origin;
		logic [31:0] depth_shift_word;
		logic [31:0] fog_offset;
	} cfg_t;

	// result header shared by all words of one primitive
	typedef struct packed {
		logic        emitted;
		logic        supported;
		kind_t       kind;
		logic [1:0]  origin;
		logic [30:0] bin;
		reason_t     reason;
		logic [2:0]  next;
		logic [3:0]  count;
	} hdr_t;

	function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] sh);
		asr32 = 32'($signed(v) >>> sh);
	endfunction
endpackage

// File: rtl/pccb_area.sv
// ----------------------------------------------------------------------------
// pccb_area
// Signed doubled area of one triangle, two register stages.
// ----------------------------------------------------------------------------
module pccb_area (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	output logic [31:0] area
);
	// coordinates sign-extended so the low 32 bits of each product are exact
	logic signed [31:0] x0, y0, x1, y1, x2, y2;
	logic [31:0] p_s1 [6];
	logic [31:0] area_s2;

	assign x0 = 32'($signed(a[15:0])); assign y0 = 32'($signed(a[31:16]));
	assign x1 = 32'($signed(b[15:0])); assign y1 = 32'($signed(b[31:16]));
	assign x2 = 32'($signed(c[15:0])); assign y2 = 32'($signed(c[31:16]));

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= x0 * y1;
			p_s1[1] <= x1 * y2;
			p_s1[2] <= x2 * y0;
			p_s1[3] <= x0 * y2;
			p_s1[4] <= x1 * y0;
			p_s1[5] <= x2 * y1;
			area_s2 <= p_s1[0] + p_s1[1] + p_s1[2] - p_s1[3] - p_s1[4] - p_s1[5];
		end
	end
	assign area = area_s2;
endmodule

// File: rtl/pccb_cull.sv
// ----------------------------------------------------------------------------
// pccb_cull
// Four-stage cull, depth bin and packet assembly pipeline.
// ----------------------------------------------------------------------------
module pccb_cull (
	input  logic          clk,
	input  logic          arst_n,
	input  pccb_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [532:0]  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output pccb_pkg::hdr_t out_hdr,
	output logic [31:0]   out_pk [13]
);
	import pccb_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, en;
	logic [532:0] d_s1, d_s2, d_s3;
	logic [31:0] af, ao;
	// stage 3 results
	logic s3_rej, s3_second, s3_full;
	reason_t s3_rsn;
	logic [1:0] s3_origin;
	logic [31:0] s3_depth;
	hdr_t hdr_s4;
	logic [31:0] pk_s4 [13];

	assign en = !v_s4 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= in_data; d_s2 <= d_s1; d_s3 <= d_s2;
		end
	end

	pccb_area u_af (.clk, .en, .a(d_s1[223:192]), .b(d_s1[287:256]), .c(d_s1[351:320]),
		.area(af));
	pccb_area u_ao (.clk, .en, .a(d_s1[287:256]), .b(d_s1[351:320]), .c(d_s1[415:384]),
		.area(ao));

	// field views of stage 3 data
	logic [31:0] ctl, mat, w2, w3, w4, w5, semi;
	logic [31:0] xy [4];
	logic [31:0] col [4];
	logic [31:0] dep [4];
	logic [4:0]  oc [4];
	logic quad, tex, two, ocen, bb;
	logic [2:0] nxt;
	always_comb begin
		ctl = d_s3[31:0]; mat = d_s3[63:32];
		w2 = d_s3[95:64]; w3 = d_s3[127:96]; w4 = d_s3[159:128]; w5 = d_s3[191:160];
		for (int i = 0; i < 4; i++) begin
			xy[i]  = d_s3[192 + 64*i +: 32];
			col[i] = d_s3[224 + 64*i +: 32];
			dep[i] = {16'd0, d_s3[448 + 16*i +: 16]};
			oc[i]  = d_s3[512 + 5*i +: 5];
		end
		quad = ctl[31]; tex = ctl[1]; two = ctl[0];
		ocen = cfg.depth_shift_word[31];
		bb = quad && ctl[2];
		semi = {6'd0, mat[0], 25'd0};
		nxt = bb ? 3'd5 : (quad ? (tex ? 3'd6 : 3'd3) : (tex ? 3'd5 : 3'd2));
	end

	logic [31:0] f, s, bias, q, dsum;
	logic [4:0] sh;
	logic [1:0] a;
	logic [4:0] common;
	always_comb begin
		sh = cfg.depth_shift_word[4:0];
		s3_rej = 1'b0; s3_rsn = RSN_NONE; s3_second = 1'b0; s3_full = 1'b0;
		s3_origin = 2'd0; q = '0; s3_depth = '0;
		f = af; s = ao;
		if (two && !af[31] && af != 0) f = 32'd0 - af;
		if (two && ao[31]) s = 32'd0 - ao;
		common = oc[0] & oc[1] & oc[2] & (quad ? oc[3] : 5'h1f);
		bias = asr32(mat, 5'd28) << 1;
		dsum = '0; a = 2'd0;
		if (bb) begin
			s3_origin = 2'd3;
			dsum = (dep[0] << 2) + 32'd4 - cfg.depth_origin;
			q = asr32(dsum, sh);
			if (ocen && oc[0] != 0) begin
				s3_rej = 1'b1; s3_rsn = RSN_OUTCODE;
			end else if (dsum == 0 || dsum[31] || q[31]) begin
				s3_rej = 1'b1; s3_rsn = RSN_DEPTH;
			end
		end else begin
			if (!quad) begin
				s3_origin = 2'd0;
			end else if (!f[31]) begin
				s3_second = 1'b1; s3_origin = 2'd2;
			end else if (!s[31] && s != 0) begin
				s3_full = 1'b1; s3_origin = 2'd3;
			end else begin
				s3_origin = 2'd1;
			end
			a = s3_second ? 2'd3 : 2'd0;
			if (s3_full)
				dsum = dep[0] - cfg.depth_origin + dep[1] + dep[2] + dep[3];
			else
				dsum = dep[a] + (dep[a] >> 1) - cfg.depth_origin + dep[1] + (dep[1] >> 1)
					+ dep[2];
			q = s3_full ? asr32(dsum + (bias << sh), sh) : asr32(dsum, sh) + bias;
			if (ocen && common != 0) begin
				s3_rej = 1'b1; s3_rsn = RSN_OUTCODE;
			end else if (ctl[3]) begin
				s3_rej = 1'b1; s3_rsn = RSN_SKIP;
			end else if (!quad && (two ? af == 0 : (af == 0 || af[31]))) begin
				s3_rej = 1'b1; s3_rsn = (af == 0) ? RSN_ZERO : RSN_BACK;
			end else if (quad && !f[31] && (s == 0 || s[31])) begin
				s3_rej = 1'b1; s3_rsn = (af == 0 || ao == 0) ? RSN_ZERO : RSN_BACK;
			end else if (dsum[31] || q[31]) begin
				s3_rej = 1'b1; s3_rsn = RSN_DEPTH;
			end else if (!quad && ctl[2] && !d_s3[532]) begin
				s3_rej = 1'b1; s3_rsn = RSN_LIGHT;
			end
		end
		s3_depth = q;
	end

	// packet assembly
	logic [31:0] pk [13];
	hdr_t hdr;
	logic [31:0] uv0, uv1, uv2;
	always_comb begin
		for (int i = 0; i < 13; i++) pk[i] = '0;
		uv0 = (quad ? w3 : w2) + cfg.fog_offset;
		uv1 = quad ? w4 : w3;
		uv2 = quad ? w5 : w4;
		if (s3_second) uv0 = (uv0 & HI_MASK) | {16'd0, w5[31:16]};
		hdr.emitted = !s3_rej;
		hdr.supported = s3_rsn != RSN_LIGHT;
		hdr.reason = s3_rsn;
		hdr.next = nxt;
		hdr.origin = s3_rej ? 2'd0 : s3_origin;
		hdr.bin = s3_rej ? 31'd0 : s3_depth[30:0];
		hdr.kind = KIND_G3;
		hdr.count = 4'd1;
		if (!s3_rej) begin
			if (bb) begin
				hdr.kind = KIND_BB; hdr.count = 4'd10;
				pk[0] = CMD_T9; pk[1] = (col[0] & COL_MASK) + CMD_FT4C + semi;
				pk[2] = xy[0]; pk[3] = w2; pk[4] = xy[1]; pk[5] = w3;
				pk[6] = xy[2]; pk[7] = w4; pk[8] = xy[3]; pk[9] = w4 >> 16;
			end else if (s3_full && tex) begin
				hdr.kind = KIND_GT4; hdr.count = 4'd13;
				pk[0] = CMD_T12; pk[1] = (col[0] & COL_MASK) + CMD_GT4C + semi;
				pk[2] = xy[0]; pk[3] = w3 + cfg.fog_offset;
				pk[4] = col[1]; pk[5] = xy[1]; pk[6] = w4;
				pk[7] = col[2]; pk[8] = xy[2]; pk[9] = w5;
				pk[10] = col[3]; pk[11] = xy[3]; pk[12] = w5 >> 16;
			end else if (s3_full) begin
				hdr.kind = KIND_G4; hdr.count = 4'd9;
				pk[0] = CMD_G4; pk[1] = (col[0] & COL_MASK) + CMD_G4C + semi;
				pk[2] = xy[0]; pk[3] = col[1]; pk[4] = xy[1];
				pk[5] = col[2]; pk[6] = xy[2]; pk[7] = col[3]; pk[8] = xy[3];
			end else if (tex) begin
				hdr.kind = KIND_GT3; hdr.count = 4'd10;
				pk[0] = CMD_T9; pk[1] = (col[a] & COL_MASK) + CMD_GT3C + semi;
				pk[2] = xy[a]; pk[3] = uv0;
				pk[4] = col[1]; pk[5] = xy[1]; pk[6] = uv1;
				pk[7] = col[2]; pk[8] = xy[2]; pk[9] = uv2;
			end else begin
				hdr.kind = KIND_G3; hdr.count = 4'd7;
				pk[0] = CMD_G3; pk[1] = (col[a] & COL_MASK) + CMD_G3C + semi;
				pk[2] = xy[a]; pk[3] = col[1]; pk[4] = xy[1];
				pk[5] = col[2]; pk[6] = xy[2];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hdr_s4 <= hdr;
			pk_s4 <= pk;
		end
	end

	assign out_valid = v_s4;
	assign out_hdr = hdr_s4;
	assign out_pk = pk_s4;
endmodule

// File: rtl/pccb_ser.sv
// ----------------------------------------------------------------------------
// pccb_ser
// Serializes one packet a word per cycle onto the output stream while out_ready is high.
// ----------------------------------------------------------------------------
`include "primitive_cull_and_command_build_top_defines.svh"
module pccb_ser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pccb_pkg::hdr_t in_hdr,
	input  logic [31:0]    in_pk [13],
	output logic           out_valid,
	input  logic           out_ready,
	output logic [31:0]    out_word,
	output logic           out_last,
	output pccb_pkg::hdr_t out_hdr
);
	import pccb_pkg::*;

	logic        busy_q;
	logic [3:0]  idx_q;
	hdr_t        hdr_q;
	logic [31:0] pk_q [13];
	logic        last, done;

	assign last = (idx_q + 4'd1) == hdr_q.count;
	assign done = busy_q && out_ready && last;
	assign in_ready = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (busy_q && out_ready) begin
			if (last) busy_q <= 1'b0;
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hdr_q <= in_hdr;
			pk_q <= in_pk;
		end
	end

	assign out_valid = busy_q;
	assign out_word = pk_q[idx_q];
	assign out_last = last;
	assign out_hdr = hdr_q;

	`PCCB_ASSERT_IMP(a_idx_range, clk, arst_n, busy_q, idx_q < hdr_q.count)
	`PCCB_ASSERT_IMP(a_rej_one, clk, arst_n, busy_q && !hdr_q.emitted, last)
	`PCCB_ASSERT_NEXT(a_done_idle, clk, arst_n, done && !in_valid, !busy_q)
endmodule

// File: rtl/primitive_cull_and_command_build_top.sv
// Throughput: one result word per cycle while m_axis_tready is high; a packet has 1 to 13 words,
// sent by the word serializer; a new primitive enters the four-stage pipeline every cycle unless stalled.
// Reset: arst_n asynchronous active low clears valids and all three registers to zero.
// ----------------------------------------------------------------------------
// primitive_cull_and_command_build_top
// Primitive cull, depth bin and GPU command packet build.
// ----------------------------------------------------------------------------
module primitive_cull_and_command_build_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// control_word, material_word, uv_words_low, uv_words_high, vertex_zero..three,
	// vertex_depths, vertex_outcodes, lighting_ready
	input  logic [535:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// payload_word, emitted, supported, packet_kind, split_origin, depth_bin,
	// reject_reason, next_word
	output logic [79:0]  m_axis_tdata,
	output logic         m_axis_tlast
);
	import pccb_pkg::*;

	cfg_t cfg_q;
	logic pv, pr;
	hdr_t ph, oh;
	logic [31:0] pk [13];
	logic [31:0] word;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ORIGIN: cfg_q.depth_origin <= cfg_data;
				CFG_SHIFT:  cfg_q.depth_shift_word <= cfg_data;
				CFG_FOG:    cfg_q.fog_offset <= cfg_data;
				default: ;
			endcase
		end
	end

	pccb_cull u_cull (.clk, .arst_n, .cfg(cfg_q), .in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready), .in_data(s_axis_tdata[532:0]), .out_valid(pv),
		.out_ready(pr), .out_hdr(ph), .out_pk(pk));

	pccb_ser u_ser (.clk, .arst_n, .in_valid(pv), .in_ready(pr), .in_hdr(ph), .in_pk(pk),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_word(word),
		.out_last(m_axis_tlast), .out_hdr(oh));

	assign m_axis_tdata = {4'd0, oh.next, oh.reason, oh.bin, oh.origin, oh.kind,
		oh.supported, oh.emitted, word};
endmodule

// File: bench/tb_primitive_cull_and_command_build_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_primitive_cull_and_command_build_top
// Self-checking bench for primitive cull and command build. Primitives go in
// on the slave stream with random bursts and gaps. Each accepted primitive is
// run through a local cull and packet predictor. Every output word is checked
// against the oldest predicted word, while the receiver stalls on a pattern.
// ----------------------------------------------------------------------------
module tb_primitive_cull_and_command_build_top;
	import pccb_pkg::*;

	// last member lands in the lowest bits
	typedef struct packed {
		logic             lit;
		logic [19:0]      oc;
		logic [63:0]      dep;
		logic [3:0][63:0] vtx;
		logic [63:0]      uvh;
		logic [63:0]      uvl;
		logic [31:0]      mat;
		logic [31:0]      ctl;
	} prim_t;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
		logic        emit;
		logic        sup;
		kind_t       kind;
		logic [1:0]  origin;
		logic [30:0] bin;
		reason_t     reason;
		logic [2:0]  next;
	} cmd_word_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [535:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [79:0]  m_axis_tdata;
	logic         m_axis_tlast;

	// local copy of the block registers
	logic [31:0] origin_reg = '0;
	logic [31:0] shift_reg = '0;
	logic [31:0] fog_reg = '0;

	cmd_word_t packet_words[$];
	int        errors = 0;
	int        prims_sent = 0;
	int        words_seen = 0;
	int        burst_left = 0;

	primitive_cull_and_command_build_top uut (.*);

	always #1 clk = ~clk;

	// ---------------- predictor ----------------
	function automatic logic [31:0] ashr(input logic [31:0] v, input logic [4:0] sh);
		logic signed [31:0] t;
		t = v;
		return t >>> sh;
	endfunction

	function automatic logic [31:0] nclip(input logic [31:0] a, b, c);
		longint x0, y0, x1, y1, x2, y2, s;
		x0 = $signed(a[15:0]); y0 = $signed(a[31:16]);
		x1 = $signed(b[15:0]); y1 = $signed(b[31:16]);
		x2 = $signed(c[15:0]); y2 = $signed(c[31:16]);
		s = x0 * y1 + x1 * y2 + x2 * y0 - x0 * y2 - x1 * y0 - x2 * y1;
		return s[31:0];
	endfunction

	function automatic void queue_word(input cmd_word_t c);
		packet_words = {packet_words, c};
	endfunction

	function automatic void push_reject(input reason_t r, input logic [2:0] nx);
		cmd_word_t c;
		c = '{32'd0, 1'b1, 1'b0, r != RSN_LIGHT, KIND_G3, 2'd0, 31'd0, r, nx};
		queue_word(c);
	endfunction

	function automatic void build_packet(input prim_t p);
		logic [31:0] w[6], xy[4], col[4], dep[4], pk[13];
		logic [4:0]  oc[4];
		logic [31:0] semi, depth, bin, first, other, f, s, bias, q, uv0, uv1, uv2;
		logic [4:0]  sh, common;
		logic [2:0]  nx;
		logic [1:0]  org;
		kind_t       kind;
		bit          quad, tex, two, ocen, second, full;
		int          a, n, cnt;
		cmd_word_t   c;
		w[0] = p.ctl; w[1] = p.mat;
		w[2] = p.uvl[31:0]; w[3] = p.uvl[63:32];
		w[4] = p.uvh[31:0]; w[5] = p.uvh[63:32];
		for (int i = 0; i < 4; i++) begin
			xy[i] = p.vtx[i][31:0];
			col[i] = p.vtx[i][63:32];
			dep[i] = {16'd0, p.dep[16*i +: 16]};
			oc[i] = p.oc[5*i +: 5];
		end
		quad = p.ctl[31]; tex = p.ctl[1]; two = p.ctl[0];
		ocen = shift_reg[31]; sh = shift_reg[4:0];
		second = 0; full = 0;
		semi = {6'd0, p.mat[0], 25'd0};
		nx = quad ? (tex ? 3'd6 : 3'd3) : (tex ? 3'd5 : 3'd2);
		if (quad && p.ctl[2]) begin
			nx = 3'd5;
			if (ocen && oc[0] != 0) begin
				push_reject(RSN_OUTCODE, nx);
				return;
			end
			depth = (dep[0] << 2) + 32'd4 - origin_reg;
			if (depth == 0 || depth[31]) begin
				push_reject(RSN_DEPTH, nx);
				return;
			end
			bin = ashr(depth, sh);
			if (bin[31]) begin
				push_reject(RSN_DEPTH, nx);
				return;
			end
			kind = KIND_BB; org = 2'd3;
			pk[0] = CMD_T9;
			pk[1] = (col[0] & COL_MASK) + CMD_FT4C + semi;
			pk[2] = xy[0]; pk[3] = w[2];
			pk[4] = xy[1]; pk[5] = w[3];
			pk[6] = xy[2]; pk[7] = w[4];
			pk[8] = xy[3]; pk[9] = w[4] >> 16;
			n = 10;
		end else begin
			cnt = quad ? 4 : 3;
			if (ocen) begin
				common = 5'h1f;
				for (int i = 0; i < cnt; i++) common &= oc[i];
				if (common != 0) begin
					push_reject(RSN_OUTCODE, nx);
					return;
				end
			end
			if (p.ctl[3]) begin
				push_reject(RSN_SKIP, nx);
				return;
			end
			first = nclip(xy[0], xy[1], xy[2]);
			if (!quad) begin
				if (two ? first == 0 : (first == 0 || first[31])) begin
					push_reject(first == 0 ? RSN_ZERO : RSN_BACK, nx);
					return;
				end
				org = 2'd0;
			end else begin
				other = nclip(xy[1], xy[2], xy[3]);
				f = first; s = other;
				if (two && f != 0 && !f[31]) f = -f;
				if (two && s[31]) s = -s;
				if (!f[31]) begin
					if (s == 0 || s[31]) begin
						push_reject((first == 0 || other == 0) ? RSN_ZERO : RSN_BACK, nx);
						return;
					end
					second = 1; org = 2'd2;
				end else if (s != 0 && !s[31]) begin
					full = 1; org = 2'd3;
				end else begin
					org = 2'd1;
				end
			end
			a = second ? 3 : 0;
			if (full)
				depth = dep[0] - origin_reg + dep[1] + dep[2] + dep[3];
			else
				depth = dep[a] + (dep[a] >> 1) - origin_reg + dep[1] + (dep[1] >> 1) + dep[2];
			if (depth[31]) begin
				push_reject(RSN_DEPTH, nx);
				return;
			end
			bias = ashr(p.mat, 5'd28) << 1;
			q = full ? ashr(depth + (bias << sh), sh) : ashr(depth, sh) + bias;
			if (q[31]) begin
				push_reject(RSN_DEPTH, nx);
				return;
			end
			if (!quad && p.ctl[2] && !p.lit) begin
				push_reject(RSN_LIGHT, nx);
				return;
			end
			bin = q;
			if (full && tex) begin
				kind = KIND_GT4;
				pk[0] = CMD_T12;
				pk[1] = (col[0] & COL_MASK) + CMD_GT4C + semi;
				pk[2] = xy[0]; pk[3] = w[3] + fog_reg;
				pk[4] = col[1]; pk[5] = xy[1]; pk[6] = w[4];
				pk[7] = col[2]; pk[8] = xy[2]; pk[9] = w[5];
				pk[10] = col[3]; pk[11] = xy[3]; pk[12] = w[5] >> 16;
				n = 13;
			end else if (full) begin
				kind = KIND_G4;
				pk[0] = CMD_G4;
				pk[1] = (col[0] & COL_MASK) + CMD_G4C + semi;
				pk[2] = xy[0]; pk[3] = col[1]; pk[4] = xy[1];
				pk[5] = col[2]; pk[6] = xy[2]; pk[7] = col[3]; pk[8] = xy[3];
				n = 9;
			end else if (tex) begin
				uv0 = (quad ? w[3] : w[2]) + fog_reg;
				uv1 = quad ? w[4] : w[3];
				uv2 = quad ? w[5] : w[4];
				// second half takes its first UV low half from word 5
				if (second) uv0 = (uv0 & HI_MASK) | (w[5] >> 16);
				kind = KIND_GT3;
				pk[0] = CMD_T9;
				pk[1] = (col[a] & COL_MASK) + CMD_GT3C + semi;
				pk[2] = xy[a]; pk[3] = uv0;
				pk[4] = col[1]; pk[5] = xy[1]; pk[6] = uv1;
				pk[7] = col[2]; pk[8] = xy[2]; pk[9] = uv2;
				n = 10;
			end else begin
				kind = KIND_G3;
				pk[0] = CMD_G3;
				pk[1] = (col[a] & COL_MASK) + CMD_G3C + semi;
				pk[2] = xy[a]; pk[3] = col[1]; pk[4] = xy[1];
				pk[5] = col[2]; pk[6] = xy[2];
				n = 7;
			end
		end
		for (int i = 0; i < n; i++) begin
			c = '{pk[i], i == n - 1, 1'b1, 1'b1, kind, org, bin[30:0], RSN_NONE, nx};
			queue_word(c);
		end
	endfunction

	// ---------------- drivers ----------------
	task automatic send_prim(input prim_t p);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			if ($urandom_range(0, 2) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'd0, p};
		do @(posedge clk); while (!s_axis_tready);
		build_packet(p);
		prims_sent++;
	endtask

	// let the block drain before a register write
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (packet_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ORIGIN: origin_reg = val;
			CFG_SHIFT:  shift_reg = val;
			CFG_FOG:    fog_reg = val;
			default: ;
		endcase
	endtask

	function automatic logic [63:0] vert(input int x, input int y, input logic [31:0] col);
		logic [15:0] xs, ys;
		xs = 16'(x); ys = 16'(y);
		return {col, ys, xs};
	endfunction

	function automatic prim_t rand_prim(input bit shaped);
		prim_t p;
		p = 533'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom});
		if (shaped) begin
			for (int i = 0; i < 4; i++)
				p.vtx[i] = vert($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
					$urandom);
			p.ctl[3] = ($urandom_range(0, 9) == 0);
			p.ctl[2] = ($urandom_range(0, 3) == 0);
			p.ctl[31] = 1'($urandom_range(0, 1));
			p.oc = ($urandom_range(0, 3) == 0) ? p.oc : 20'd0;
			p.lit = ($urandom_range(0, 4) != 0);
			p.mat[31:28] = ($urandom_range(0, 1)) ? p.mat[31:28] : 4'd0;
		end
		return p;
	endfunction

	// ---------------- result checker ----------------
	logic [15:0] stall_lfsr = 16'hace1;
	int          stall_cnt = 0;

	always @(posedge clk) begin
		cmd_word_t got, want;
		stall_lfsr <= {stall_lfsr[14:0], stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12]
			^ stall_lfsr[10]};
		stall_cnt <= stall_cnt + 1;
		// alternate stretches of full speed and patterned stalls
		m_axis_tready <= stall_cnt[8] ? 1'b1 : (stall_lfsr[2:0] != 3'd0);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[31:0], m_axis_tlast, m_axis_tdata[32], m_axis_tdata[33],
				kind_t'(m_axis_tdata[36:34]), m_axis_tdata[38:37], m_axis_tdata[69:39],
				reason_t'(m_axis_tdata[72:70]), m_axis_tdata[75:73]};
			words_seen++;
			if (packet_words.size() == 0) begin
				$display("%t unexpected word: got %h", $time, got);
				errors++;
			end else begin
				want = packet_words.pop_front();
				if (got !== want) begin
					$display("%t word mismatch: expected %h, got %h", $time, want, got);
					errors++;
				end
			end
		end
	end

	// ---------------- tests ----------------
	task automatic test_packet_kinds();
		prim_t p;
		p = '0;
		send_prim(p);
		send_prim('1);
		p = rand_prim(0);
		p.ctl = 32'h0; p.mat[31:28] = 4'd0;
		p.vtx[0] = vert(0, 0, 32'hffffffff);
		p.vtx[1] = vert(10, 0, 32'h12345678);
		p.vtx[2] = vert(0, 10, 32'h00abcdef);
		p.dep = 64'h0003_0002_0001_0000;
		send_prim(p);                          // G3
		p.ctl = 32'h2; send_prim(p);           // GT3
		p.mat[0] = 1'b1; send_prim(p);         // semi-transparent
		p.ctl = 32'h4; p.lit = 1'b0; send_prim(p); // lit triangle, colour not ready
		p.lit = 1'b1; send_prim(p);
		p.vtx[1] = vert(0, 10, 32'h1); p.vtx[2] = vert(10, 0, 32'h2);
		p.ctl = 32'h0; send_prim(p);           // backface
		p.ctl = 32'h1; send_prim(p);           // two-sided keeps it
		p.vtx[2] = vert(0, 20, 32'h2); send_prim(p); // zero area
		p.vtx[0] = vert(0, 0, 32'h3);
		p.vtx[1] = vert(0, 10, 32'h4);
		p.vtx[2] = vert(10, 0, 32'h5);
		p.vtx[3] = vert(10, 10, 32'h6);
		p.ctl = 32'h8000_0000; send_prim(p);   // G4 whole
		p.ctl = 32'h8000_0002; send_prim(p);   // GT4 whole
		p.vtx[3] = vert(-10, -10, 32'h7);
		send_prim(p);                          // first half only
		p.vtx[1] = vert(10, 0, 32'h4); p.vtx[2] = vert(0, 10, 32'h5);
		send_prim(p);                          // second half only
		p.ctl = 32'h8000_0000; send_prim(p);
		p.ctl = 32'h8000_0006; send_prim(p);   // billboard
		p.ctl = 32'h8000_0008; send_prim(p);   // skip
		p.vtx[0] = vert(-32768, -32768, 0); p.vtx[1] = vert(32767, -32768, 0);
		p.vtx[2] = vert(-32768, 32767, 0); p.ctl = 32'h1;
		send_prim(p);                          // extreme area, two-sided
		p.mat[31:28] = 4'h8; p.ctl = 32'h0; send_prim(p); // most negative bias
	endtask

	task automatic test_rejects_with_config();
		prim_t p;
		write_reg(CFG_SHIFT, 32'h8000_0003);
		write_reg(CFG_ORIGIN, 32'd4);
		write_reg(CFG_FOG, 32'hffff_ffff);
		p = rand_prim(1);
		p.ctl = 32'h8000_0004; p.dep = '0; p.oc = '0;
		send_prim(p);                          // billboard depth zero
		p.oc = 20'h1; send_prim(p);            // billboard outcode
		p.ctl = 32'h0; p.oc = 20'h0_0421; send_prim(p); // common outcode
		p.oc = 20'h0_0021; send_prim(p);
		p.ctl = 32'h2; p.oc = '0;
		p.vtx[0] = vert(0, 0, 1); p.vtx[1] = vert(9, 0, 2); p.vtx[2] = vert(0, 9, 3);
		send_prim(p);
		write_reg(CFG_ORIGIN, 32'hffff_ffff);  // depth sum wraps
		send_prim(p);
		p.dep = '1; send_prim(p);
		write_reg(2'd3, 32'hdead_beef);        // unmapped index, no effect
		send_prim(p);
	endtask

	task automatic test_random_traffic(input int count);
		for (int i = 0; i < count; i++)
			send_prim(rand_prim($urandom_range(0, 6) != 0));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_packet_kinds();
		test_rejects_with_config();
		write_reg(CFG_ORIGIN, 32'd0);
		write_reg(CFG_SHIFT, 32'd0);
		write_reg(CFG_FOG, $urandom);
		test_random_traffic(40);
		write_reg(CFG_ORIGIN, $urandom_range(0, 3000));
		write_reg(CFG_SHIFT, 32'h8000_001f);
		test_random_traffic(40);
		write_reg(CFG_SHIFT, $urandom_range(0, 31) | ($urandom_range(0, 1) << 31));
		write_reg(CFG_FOG, 32'h0);
		test_random_traffic(40);
		wait_idle();
		$display("Sent %0d primitives, checked %0d packet words.", prims_sent, words_seen);
		if (errors == 0 && packet_words.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out waiting for the block.");
		$display("DONE: errors detected");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/pccb_pkg.sv
rtl/pccb_area.sv
rtl/pccb_cull.sv
rtl/pccb_ser.sv
rtl/primitive_cull_and_command_build_top.sv
bench/tb_primitive_cull_and_command_build_top.sv
